[hw/rtl/spms_pkg.sv]
// Shared types, sizes and codes for the shared-pool multi-stack core.
package spms_pkg;

    localparam int POOL_SLOTS  = 256;
    localparam int STACK_COUNT = 3;

    localparam int VALUE_W    = 32;
    localparam int STACK_ID_W = 2;
    localparam int IDX_W      = $clog2(POOL_SLOTS);
    // one more code than there are slots: POOL_SLOTS itself is the null link
    localparam int SLOT_W     = $clog2(POOL_SLOTS + 1);
    localparam int STK_W      = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;

    localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(POOL_SLOTS);

    typedef enum logic
    {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        mode_t                      mode;
        logic [STACK_ID_W-1:0]      stack_id;
        logic signed [VALUE_W-1:0]  push_value;
    } req_t;

    typedef struct packed
    {
        logic signed [VALUE_W-1:0]  popped_value;
        status_t                    status;
    } res_t;

    // one pool slot: stored value and link (next entry down, or next free slot)
    typedef struct packed
    {
        logic [VALUE_W-1:0] value;
        logic [SLOT_W-1:0]  link;
    } entry_t;

endpackage

[hw/rtl/spms_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
module spms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/shared_pool_multi_stack_core.sv]
// Top level: several stacks kept as linked lists in one shared pool of slots.
//
//  channel  | handshake              | payload | direction
//  ---------+------------------------+---------+----------
//  request  | req_valid / req_ready  | req     | in
//  result   | res_valid / res_ready  | res     | out
//
// Each request: the accept cycle in S_IDLE issues the pool RAM read, then
// S_ACCESS uses the read data and writes the slot back.
// The single pool RAM (read then write of one entry) makes both states needed.
// Reset: all stacks empty, free list empty, fresh-slot counter at zero; no
// clearing pass, the block takes requests right after reset.
// A result waits in an output register; a new request is accepted meanwhile,
// and the write cycle holds only while that register is full and res_ready low.
module shared_pool_multi_stack_core
    import spms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  logic req_valid,
    output logic req_ready,
    input  req_t req,

    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic
    {
        S_IDLE   = 1'b0,
        S_ACCESS = 1'b1
    } state_t;

    state_t state_reg;

    // Stack tops and free-slot bookkeeping. Freed slots form a linked free
    // list through the link field; slots never used yet come from fresh_reg.
    logic [SLOT_W-1:0] top_reg [STACK_COUNT];
    logic [SLOT_W-1:0] free_head_reg;
    logic [SLOT_W-1:0] fresh_reg;

    // request held for the write cycle
    mode_t              mode_reg;
    logic [STK_W-1:0]   sid_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               ok_reg;
    logic               from_list_reg;

    logic res_valid_reg;
    res_t res_reg;

    // accept-side decode
    logic              accept;
    logic              sid_ok;
    logic [STK_W-1:0]  sid_idx;
    logic [SLOT_W-1:0] top_sel;
    logic              list_avail;
    logic              fresh_avail;
    logic              op_ok;
    logic              op_from_list;
    logic [IDX_W-1:0]  op_slot;

    // write cycle
    logic   fire;
    logic   rd_en;
    logic   wr_en;
    entry_t wr_entry;
    entry_t rd_entry;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign sid_ok      = (int'(req.stack_id) < STACK_COUNT);
    assign sid_idx     = STK_W'(req.stack_id);
    assign top_sel     = sid_ok ? top_reg[sid_idx] : NULL_SLOT;
    assign list_avail  = (free_head_reg != NULL_SLOT);
    assign fresh_avail = (fresh_reg != NULL_SLOT);

    always_comb
    begin
        op_ok        = 1'b0;
        op_from_list = 1'b0;
        op_slot      = '0;
        case (req.mode)
            MODE_PUSH:
            begin
                // any free slot will do: only the count of used slots is visible
                op_ok        = sid_ok && (list_avail || fresh_avail);
                op_from_list = list_avail;
                op_slot      = list_avail ? free_head_reg[IDX_W-1:0]
                                          : fresh_reg[IDX_W-1:0];
            end
            MODE_POP:
            begin
                op_ok   = (top_sel != NULL_SLOT);
                op_slot = top_sel[IDX_W-1:0];
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // read only when the entry's link matters: pop, or push from the free list
    assign rd_en = accept && op_ok && ((req.mode == MODE_POP) || op_from_list);

    assign fire  = (state_reg == S_ACCESS) && (!res_valid_reg || res_ready);
    assign wr_en = fire && ok_reg;

    always_comb
    begin
        if (mode_reg == MODE_PUSH)
        begin
            wr_entry.value = val_reg;
            wr_entry.link  = top_reg[sid_reg];
        end
        else
        begin
            // freed slot joins the head of the free list
            wr_entry.value = rd_entry.value;
            wr_entry.link  = free_head_reg;
        end
    end

    spms_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (POOL_SLOTS)
    ) u_pool (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (op_slot),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                top_reg[i] <= NULL_SLOT;
            end
            free_head_reg <= NULL_SLOT;
            fresh_reg     <= '0;
            mode_reg      <= MODE_PUSH;
            sid_reg       <= '0;
            val_reg       <= '0;
            slot_reg      <= '0;
            ok_reg        <= 1'b0;
            from_list_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '{popped_value: '0, status: ST_DONE};
        end
        else
        begin
            // drained result; a new one from fire takes its place instead
            if (res_valid_reg && res_ready && !fire)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg      <= req.mode;
                        sid_reg       <= sid_idx;
                        val_reg       <= req.push_value;
                        slot_reg      <= op_slot;
                        ok_reg        <= op_ok;
                        from_list_reg <= op_from_list;
                        state_reg     <= S_ACCESS;
                    end
                end
                S_ACCESS:
                begin
                    if (fire)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (!ok_reg)
                        begin
                            res_reg.popped_value <= '0;
                            res_reg.status <= (mode_reg == MODE_PUSH) ? ST_FULL : ST_EMPTY;
                        end
                        else if (mode_reg == MODE_PUSH)
                        begin
                            res_reg.popped_value <= '0;
                            res_reg.status       <= ST_DONE;
                            top_reg[sid_reg]     <= SLOT_W'(slot_reg);
                            if (from_list_reg)
                            begin
                                free_head_reg <= rd_entry.link;
                            end
                            else
                            begin
                                fresh_reg <= fresh_reg + SLOT_W'(1);
                            end
                        end
                        else
                        begin
                            res_reg.popped_value <= rd_entry.value;
                            res_reg.status       <= ST_DONE;
                            top_reg[sid_reg]     <= rd_entry.link;
                            free_head_reg        <= SLOT_W'(slot_reg);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // every slot on the free list was handed out from the fresh range before
    a_free_head_used: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg != NULL_SLOT) |-> (free_head_reg < fresh_reg))
        else $error("free list head points at a never-used slot");

    // a successful pop always frees a slot that was allocated
    a_pop_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ok_reg && (mode_reg == MODE_POP)) |-> (SLOT_W'(slot_reg) < fresh_reg))
        else $error("pop of a slot outside the allocated range");

    // a result only appears from the write cycle
    a_res_from_access: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_ACCESS))
        else $error("result raised outside the write cycle");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request accepted while one is in flight");
`endif

endmodule
